// ----- hdl/gbn_pkg.sv -----
// Shared types, widths and a helper function for the greedy box suppression block.
package gbn_pkg;

    localparam int COORD_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int THR_W    = 16;
    localparam int ENTRY_W  = 4 * COORD_W + SCORE_W;
    localparam int SPAN_W   = 17;
    localparam int AREA_W   = 2 * SPAN_W - 1;
    localparam int UNION_W  = AREA_W + 1;
    localparam int LHS_W    = AREA_W + THR_W;
    localparam int RHS_W    = UNION_W + THR_W;
    localparam logic [THR_W-1:0] THR_RESET = 16'h8000;
    localparam logic signed [COORD_W+1:0] ONE_PIXEL = 18'sd16;

    // Register byte addresses.
    localparam logic [2:0] ADDR_IOU_THR = 3'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;
        logic ovf_set;
        logic sel_rd;
        logic sup_rd;
        logic emit;
        logic emit_last;
        logic take_best;
        logic emit_empty;
        logic frame_clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic best_found;
        logic kept_valid;
        logic pipe_busy;
        logic out_busy;
    } t_status;

    // Inclusive extent (hi - lo + one pixel), clamped at zero.
    function automatic logic [SPAN_W-1:0] span(input logic signed [COORD_W-1:0] lo,
                                               input logic signed [COORD_W-1:0] hi);
        logic signed [COORD_W+1:0] s;
        s = (COORD_W+2)'(hi) - (COORD_W+2)'(lo) + ONE_PIXEL;
        return s[COORD_W+1] ? '0 : s[SPAN_W-1:0];
    endfunction

endpackage

// ----- hdl/gbn_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/gbn_ctrl.sv -----
// Controller for loading a frame and sequencing the select and suppress scans.
module gbn_ctrl #(
    parameter int MAX_BOXES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_box_present,
    input  logic                            i_frame_end,
    output logic                            o_ready,
    input  gbn_pkg::t_status                i_status,
    output gbn_pkg::t_cmd                   o_cmd,
    output logic [$clog2(MAX_BOXES+1)-1:0]  o_addr
);
    localparam int CW = $clog2(MAX_BOXES + 1);

    localparam logic [2:0] S_LOAD     = 3'd0;
    localparam logic [2:0] S_SEL      = 3'd1;
    localparam logic [2:0] S_SEL_WAIT = 3'd2;
    localparam logic [2:0] S_EMIT     = 3'd3;
    localparam logic [2:0] S_SUP      = 3'd4;
    localparam logic [2:0] S_SUP_WAIT = 3'd5;
    localparam logic [2:0] S_EMPTY    = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          accept;
    logic          has_room;

    assign o_ready  = (r_state == S_LOAD);
    assign accept   = i_valid && o_ready;
    assign has_room = (r_count < CW'(MAX_BOXES));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_addr  = r_idx;
        case (r_state)
            S_LOAD: begin
                o_addr = r_count;
                n_idx  = '0;
                if (accept) begin
                    if (i_box_present && has_room) begin
                        o_cmd.wr = 1'b1;
                        n_count  = r_count + CW'(1);
                    end else if (i_box_present) begin
                        o_cmd.ovf_set = 1'b1;
                    end
                    if (i_frame_end) begin
                        n_state = (n_count == '0) ? S_EMPTY : S_SEL;
                    end
                end
            end
            S_SEL: begin
                o_cmd.sel_rd = 1'b1;
                if (r_idx == r_count - CW'(1)) begin
                    n_state = S_SEL_WAIT;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SEL_WAIT: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    // The previously kept box goes out now; it is the last one when
                    // this scan found nothing left.
                    o_cmd.emit      = i_status.kept_valid;
                    o_cmd.emit_last = !i_status.best_found;
                    o_cmd.take_best = i_status.best_found;
                    n_idx           = '0;
                    n_state         = i_status.best_found ? S_SUP : S_DONE;
                end
            end
            S_SUP: begin
                o_cmd.sup_rd = 1'b1;
                if (r_idx == r_count - CW'(1)) begin
                    n_state = S_SUP_WAIT;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_SUP_WAIT: begin
                n_idx = '0;
                if (!i_status.pipe_busy) begin
                    n_state = S_SEL;
                end
            end
            S_EMPTY: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.frame_clear = 1'b1;
                n_count           = '0;
                n_state           = S_LOAD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOXES))
        else $error("box count exceeds capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_count == '0) && (r_state == S_LOAD))
        else $error("frame not cleared after completion");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL || r_state == S_SUP) |-> (r_count != '0))
        else $error("scan started on an empty store");
endmodule

// ----- hdl/gbn_dp.sv -----
// Datapath: box store, best-score search, IoU pipeline, marks and output register.
module gbn_dp #(
    parameter int MAX_BOXES = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  gbn_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(MAX_BOXES+1)-1:0]         i_addr,
    output gbn_pkg::t_status                       o_status,
    input  logic [gbn_pkg::THR_W-1:0]              i_thr,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_left,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_top,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_right,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_bottom,
    input  logic [gbn_pkg::SCORE_W-1:0]            i_box_score,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_left,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_top,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_right,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_bottom,
    output logic [gbn_pkg::SCORE_W-1:0]            o_kept_score,
    output logic                                   o_empty_frame,
    output logic                                   o_overflowed,
    output logic                                   o_last_result
);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CORW = gbn_pkg::COORD_W;

    logic [gbn_pkg::ENTRY_W-1:0] wdata, rdata;

    assign wdata = {i_box_left, i_box_top, i_box_right, i_box_bottom, i_box_score};

    gbn_ram #(
        .WIDTH (gbn_pkg::ENTRY_W),
        .DEPTH (MAX_BOXES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_addr[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (i_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    logic [MAX_BOXES-1:0] r_marks;
    logic                 r_ovf;

    // Read tracking: the store data arrives in the cycle after its address.
    logic          r_rd_sel_v, r_rd_sup_v;
    logic [AW-1:0] r_rd_idx;

    // Best candidate of the current select scan.
    logic                        r_best_v;
    logic [AW-1:0]               r_best_idx;
    logic [gbn_pkg::ENTRY_W-1:0] r_best;
    logic                        r_kept_v;
    logic [gbn_pkg::ENTRY_W-1:0] r_kept;

    logic rd_unmarked;
    logic better;

    assign rd_unmarked = !r_marks[r_rd_idx];
    assign better = !r_best_v ||
                    (rdata[gbn_pkg::SCORE_W-1:0] > r_best[gbn_pkg::SCORE_W-1:0]);

    // Overlap pipeline.
    logic signed [CORW-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic signed [CORW-1:0] x1, y1, x2, y2;

    assign al = r_kept[4*CORW+15 -: CORW];
    assign at = r_kept[3*CORW+15 -: CORW];
    assign ar = r_kept[2*CORW+15 -: CORW];
    assign ab = r_kept[CORW+15 -: CORW];
    assign bl = rdata[4*CORW+15 -: CORW];
    assign bt = rdata[3*CORW+15 -: CORW];
    assign br = rdata[2*CORW+15 -: CORW];
    assign bb = rdata[CORW+15 -: CORW];
    assign x1 = (al > bl) ? al : bl;
    assign y1 = (at > bt) ? at : bt;
    assign x2 = (ar < br) ? ar : br;
    assign y2 = (ab < bb) ? ab : bb;

    logic                         r_s1_v;
    logic [AW-1:0]                r_s1_idx;
    logic [gbn_pkg::SPAN_W-1:0]   r_wa, r_ha, r_wb, r_hb, r_wi, r_hi;
    logic                         r_s2_v;
    logic [AW-1:0]                r_s2_idx;
    logic [gbn_pkg::AREA_W-1:0]   r_area_a, r_area_b, r_inter2;
    logic                         r_s3_v;
    logic [AW-1:0]                r_s3_idx;
    logic [gbn_pkg::AREA_W-1:0]   r_inter3;
    logic [gbn_pkg::UNION_W-1:0]  r_union;
    logic                         r_s4_v;
    logic [AW-1:0]                r_s4_idx;
    logic [gbn_pkg::AREA_W-1:0]   r_inter4;
    logic [gbn_pkg::RHS_W-1:0]    r_rhs;
    logic                         r_union_pos;
    logic [gbn_pkg::LHS_W-1:0]    lhs;
    logic                         hit;

    assign lhs = {r_inter4, {gbn_pkg::THR_W{1'b0}}};
    assign hit = r_s4_v && r_union_pos && (gbn_pkg::RHS_W'(lhs) > r_rhs);

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_rd_idx;
        r_wa     <= gbn_pkg::span(al, ar);
        r_ha     <= gbn_pkg::span(at, ab);
        r_wb     <= gbn_pkg::span(bl, br);
        r_hb     <= gbn_pkg::span(bt, bb);
        r_wi     <= gbn_pkg::span(x1, x2);
        r_hi     <= gbn_pkg::span(y1, y2);
        r_s2_idx <= r_s1_idx;
        r_area_a <= gbn_pkg::AREA_W'(r_wa) * gbn_pkg::AREA_W'(r_ha);
        r_area_b <= gbn_pkg::AREA_W'(r_wb) * gbn_pkg::AREA_W'(r_hb);
        r_inter2 <= gbn_pkg::AREA_W'(r_wi) * gbn_pkg::AREA_W'(r_hi);
        r_s3_idx <= r_s2_idx;
        r_inter3 <= r_inter2;
        r_union  <= gbn_pkg::UNION_W'(r_area_a) + gbn_pkg::UNION_W'(r_area_b)
                    - gbn_pkg::UNION_W'(r_inter2);
        r_s4_idx <= r_s3_idx;
        r_inter4 <= r_inter3;
        r_rhs    <= gbn_pkg::RHS_W'(i_thr) * gbn_pkg::RHS_W'(r_union);
        r_union_pos <= (r_union != '0);
        r_rd_idx <= i_addr[AW-1:0];
        if (r_rd_sel_v && rd_unmarked && better) begin
            r_best     <= rdata;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.take_best) begin
            r_kept <= r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks    <= '0;
            r_ovf      <= 1'b0;
            r_rd_sel_v <= 1'b0;
            r_rd_sup_v <= 1'b0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_s4_v     <= 1'b0;
            r_best_v   <= 1'b0;
            r_kept_v   <= 1'b0;
        end else begin
            r_rd_sel_v <= i_cmd.sel_rd;
            r_rd_sup_v <= i_cmd.sup_rd;
            r_s1_v     <= r_rd_sup_v && rd_unmarked;
            r_s2_v     <= r_s1_v;
            r_s3_v     <= r_s2_v;
            r_s4_v     <= r_s3_v;
            if (r_rd_sel_v && rd_unmarked && better) begin
                r_best_v <= 1'b1;
            end
            if (i_cmd.ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (hit) begin
                r_marks[r_s4_idx] <= 1'b1;
            end
            if (i_cmd.emit && i_cmd.emit_last) begin
                r_kept_v <= 1'b0;
            end
            if (i_cmd.take_best) begin
                r_kept_v             <= 1'b1;
                r_best_v             <= 1'b0;
                r_marks[r_best_idx]  <= 1'b1;
            end
            if (i_cmd.frame_clear) begin
                r_marks  <= '0;
                r_ovf    <= 1'b0;
                r_best_v <= 1'b0;
                r_kept_v <= 1'b0;
            end
        end
    end

    // Output register: holds one result until its transfer completes.
    logic                        r_out_v;
    logic [gbn_pkg::ENTRY_W-1:0] r_out_box;
    logic                        r_out_empty, r_out_ovf, r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_empty) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_box   <= r_kept;
            r_out_empty <= 1'b0;
            r_out_ovf   <= r_ovf;
            r_out_last  <= i_cmd.emit_last;
        end else if (i_cmd.emit_empty) begin
            r_out_box   <= '0;
            r_out_empty <= 1'b1;
            r_out_ovf   <= r_ovf;
            r_out_last  <= 1'b1;
        end
    end

    assign o_valid       = r_out_v;
    assign o_kept_left   = r_out_box[4*CORW+15 -: CORW];
    assign o_kept_top    = r_out_box[3*CORW+15 -: CORW];
    assign o_kept_right  = r_out_box[2*CORW+15 -: CORW];
    assign o_kept_bottom = r_out_box[CORW+15 -: CORW];
    assign o_kept_score  = r_out_box[gbn_pkg::SCORE_W-1:0];
    assign o_empty_frame = r_out_empty;
    assign o_overflowed  = r_out_ovf;
    assign o_last_result = r_out_last;

    assign o_status.best_found = r_best_v;
    assign o_status.kept_valid = r_kept_v;
    assign o_status.pipe_busy  = r_rd_sel_v || r_rd_sup_v || r_s1_v || r_s2_v ||
                                 r_s3_v || r_s4_v;
    assign o_status.out_busy   = r_out_v;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_best |-> !o_status.pipe_busy)
        else $error("best box taken while a scan is still in flight");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_empty) |-> r_out_last)
        else $error("empty frame marker not flagged as last result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.emit_empty) |-> !r_out_v)
        else $error("output register overwritten before its transfer");
endmodule

// ----- hdl/greedy_box_nms.sv -----
// Top level of the greedy IoU box suppression block with its APB register.
// Boxes of one frame load at one per cycle until the item that carries frame_end.
// Suppression then runs over the box store: each round is a select scan of N reads,
// a wait for the best box to settle, the emit of the previous kept box once the
// output register is free, then a suppress scan of N reads and a drain of the read
// and the four-stage IoU pipeline. Scan reads are serialised by the single read
// port of the store, and a stalled receiver delays each emit. Input is not taken
// during suppression. Kept boxes leave in descending score order, ties to the
// earlier arrival; the last one carries last_result.
module greedy_box_nms #(
    parameter int MAX_BOXES = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_left,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_top,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_right,
    input  logic signed [gbn_pkg::COORD_W-1:0]     i_box_bottom,
    input  logic [gbn_pkg::SCORE_W-1:0]            i_box_score,
    input  logic                                   i_box_present,
    input  logic                                   i_frame_end,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_left,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_top,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_right,
    output logic signed [gbn_pkg::COORD_W-1:0]     o_kept_bottom,
    output logic [gbn_pkg::SCORE_W-1:0]            o_kept_score,
    output logic                                   o_empty_frame,
    output logic                                   o_overflowed,
    output logic                                   o_last_result
);
    logic [gbn_pkg::THR_W-1:0]       r_iou_thr;
    gbn_pkg::t_cmd                   cmd;
    gbn_pkg::t_status                status;
    logic [$clog2(MAX_BOXES+1)-1:0]  addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_thr <= gbn_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr == gbn_pkg::ADDR_IOU_THR) begin
            r_iou_thr <= pwdata[gbn_pkg::THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == gbn_pkg::ADDR_IOU_THR) ? {16'b0, r_iou_thr} : 32'b0;

    gbn_ctrl #(
        .MAX_BOXES (MAX_BOXES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_box_present (i_box_present),
        .i_frame_end   (i_frame_end),
        .o_ready       (o_ready),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_addr        (addr)
    );

    gbn_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_addr        (addr),
        .o_status      (status),
        .i_thr         (r_iou_thr),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_right   (i_box_right),
        .i_box_bottom  (i_box_bottom),
        .i_box_score   (i_box_score),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kept_left   (o_kept_left),
        .o_kept_top    (o_kept_top),
        .o_kept_right  (o_kept_right),
        .o_kept_bottom (o_kept_bottom),
        .o_kept_score  (o_kept_score),
        .o_empty_frame (o_empty_frame),
        .o_overflowed  (o_overflowed),
        .o_last_result (o_last_result)
    );
endmodule
